### sv/bnms_pkg.sv
`default_nettype none
package bnms_pkg;

  typedef struct packed {
    logic [14:0] center_x;
    logic [14:0] center_y;
    logic [14:0] box_width;
    logic [14:0] box_height;
    logic [15:0] confidence;
    logic [7:0]  class_index;
    logic        frame_end;
  } box_in_t;

  typedef struct packed {
    logic [14:0] kept_x;
    logic [14:0] kept_y;
    logic [14:0] kept_width;
    logic [14:0] kept_height;
    logic [15:0] kept_score;
    logic [7:0]  kept_class;
    logic        last_kept;
    logic        boxes_dropped;
  } box_out_t;

  localparam logic [15:0] THRESH_RESET = 16'd32768;

endpackage
`default_nettype wire

### sv/box_non_max_suppression_top.sv
`default_nettype none
// Greedy class-agnostic non-maximum suppression. Boxes are loaded one word per
// cycle into a box memory and a score memory (MAX_BOXES entries each); boxes
// past capacity are dropped and every result of that frame carries
// boxes_dropped. The word with frame_end starts suppression: a scan pass reads
// the score memory one entry a cycle to find the highest surviving score
// (earliest wins ties), the winner is marked and emitted, then a suppress pass
// reads the box memory one entry a cycle and marks every surviving box whose
// IoU with the winner exceeds overlap_threshold (inter*65536 > t*union, exact).
// The IoU test is pipelined over four register stages after the memory read.
// Removal marks are per-entry flip-flops cleared at frame end. After the
// frame_end word, each kept box takes a scan pass, a fetch of the winner, a
// suppress pass and an emit that waits out any output stall; a final scan that
// finds no survivor leads to a clear step. Input is held off (in_stall) until
// the block is back to loading.
// Configuration writes are accepted at any time (cfg_ready is tied high) and
// must only be made while the block is idle.
module box_non_max_suppression_top #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bnms_pkg::box_in_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bnms_pkg::box_out_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);
  import bnms_pkg::*;

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN, S_PICK, S_SUPP, S_EMIT, S_DONE
  } state_t;

  state_t state;

  // stores
  logic [59:0] box_mem   [MAX_BOXES];
  logic [23:0] score_mem [MAX_BOXES];
  logic [59:0] box_rd;
  logic [23:0] score_rd;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [CW-1:0] count;
  logic          overflow;
  logic [MAX_BOXES-1:0] removed;
  logic [15:0]   thresh;

  // scan pass
  logic [CW-1:0] idx;         // issued read index
  logic          rd_v;        // read data valid this cycle
  logic [AW-1:0] rd_idx;      // index of read data
  logic          best_v;
  logic [AW-1:0] best_idx;
  logic [15:0]   best_score;
  logic [59:0]   best_box;
  logic [7:0]    best_class;
  logic          any_left;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_LOAD);
  assign wr_en     = in_valid && !in_stall && (count < CW'(MAX_BOXES));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_mem[count[AW-1:0]] <= {in_data.box_height, in_data.box_width,
                                 in_data.center_y, in_data.center_x};
      score_mem[count[AW-1:0]] <= {in_data.class_index, in_data.confidence};
    end
    box_rd   <= box_mem[rd_addr];
    score_rd <= score_mem[rd_addr];
  end

  assign rd_addr = (state == S_PICK) ? best_idx : idx[AW-1:0];

  // IoU pipeline: stage 1 overlap extents, stage 2 products, stage 3 union, stage 4 compare
  // signed edges (18 bit) to cover 2x-w < 0
  logic signed [17:0] bl, br, bt, bb, al, ar, at, ab;
  always_comb begin
    al = $signed({1'b0, best_box[14:0], 1'b0}) - $signed({3'b0, best_box[44:30]});
    ar = $signed({1'b0, best_box[14:0], 1'b0}) + $signed({3'b0, best_box[44:30]});
    at = $signed({1'b0, best_box[29:15], 1'b0}) - $signed({3'b0, best_box[59:45]});
    ab = $signed({1'b0, best_box[29:15], 1'b0}) + $signed({3'b0, best_box[59:45]});
    bl = $signed({1'b0, box_rd[14:0], 1'b0}) - $signed({3'b0, box_rd[44:30]});
    br = $signed({1'b0, box_rd[14:0], 1'b0}) + $signed({3'b0, box_rd[44:30]});
    bt = $signed({1'b0, box_rd[29:15], 1'b0}) - $signed({3'b0, box_rd[59:45]});
    bb = $signed({1'b0, box_rd[29:15], 1'b0}) + $signed({3'b0, box_rd[59:45]});
  end

  logic          p1_v, p2_v, p3_v, p4_v;
  logic [AW-1:0] p1_i, p2_i, p3_i, p4_i;
  logic          p1_ok, p2_ok, p3_ok;
  logic [16:0]   p1_dx, p1_dy;
  logic [14:0]   p1_bw, p1_bh;
  logic [33:0]   p2_inter;
  logic [29:0]   p2_aa, p2_ba;
  logic [33:0]   p3_inter;
  logic [32:0]   p3_uni;
  logic          p4_hit;
  logic signed [17:0] lft, rgt, tp, bt2;

  always_comb begin
    lft = (al > bl) ? al : bl;
    rgt = (ar < br) ? ar : br;
    tp  = (at > bt) ? at : bt;
    bt2 = (ab < bb) ? ab : bb;
  end

  always_ff @(posedge clk) begin
    p1_dx <= 17'(rgt - lft);
    p1_dy <= 17'(bt2 - tp);
    p1_ok <= !(tp > bt2) && !(lft > rgt);
    p1_bw <= box_rd[44:30];
    p1_bh <= box_rd[59:45];
    p1_i  <= rd_idx;
    p2_inter <= p1_dx * p1_dy;
    p2_aa <= best_box[44:30] * best_box[59:45];
    p2_ba <= p1_bw * p1_bh;
    p2_ok <= p1_ok;
    p2_i  <= p1_i;
    p3_inter <= p2_inter;
    p3_uni   <= 33'({p2_aa, 2'b0}) + 33'({p2_ba, 2'b0}) - 33'(p2_inter);
    p3_ok    <= p2_ok;
    p3_i     <= p2_i;
    p4_hit   <= p3_ok && ({p3_inter, 16'b0} > (50'(thresh) * 50'(p3_uni)));
    p4_i     <= p3_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      overflow <= 1'b0;
      removed <= '0;
      thresh <= THRESH_RESET;
      out_valid <= 1'b0;
      idx <= '0;
      rd_v <= 1'b0;
      best_v <= 1'b0;
      any_left <= 1'b0;
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0; p4_v <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) thresh <= cfg_data;
      p1_v <= (state == S_SUPP) && any_left && rd_v;
      p2_v <= p1_v; p3_v <= p2_v; p4_v <= p3_v;
      // word held in emit until taken; otherwise drops once taken
      if (state == S_EMIT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (in_valid && !in_stall) begin
            if (wr_en) begin
              removed[count[AW-1:0]] <= 1'b0;
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            if (in_data.frame_end) begin
              state <= S_SCAN;
              idx <= '0;
              rd_v <= 1'b0;
              best_v <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // issue reads, compare returned entries
          rd_v   <= (idx < count);
          rd_idx <= idx[AW-1:0];
          if (idx < count) idx <= idx + 1'b1;
          if (rd_v && !removed[rd_idx] &&
              (!best_v || score_rd[15:0] > best_score)) begin
            best_v <= 1'b1;
            best_idx <= rd_idx;
            best_score <= score_rd[15:0];
          end
          if (!rd_v && idx >= count) begin
            if (best_v) begin
              state <= S_PICK;
              removed[best_idx] <= 1'b1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PICK: begin
          // read address is best_idx this cycle; capture next cycle
          state <= S_SUPP;
          idx <= '0;
          rd_v <= 1'b0;
          any_left <= 1'b0;
        end
        S_SUPP: begin
          if (!rd_v && idx == '0 && !p1_v && !p2_v && !p3_v && !p4_v &&
              !any_left) begin
            best_box   <= box_rd;
            best_class <= score_rd[23:16];
            any_left   <= 1'b1; // best captured
          end
          if (any_left) begin
            rd_v   <= (idx < count);
            rd_idx <= idx[AW-1:0];
            if (idx < count) idx <= idx + 1'b1;
            if (p4_v && p4_hit) removed[p4_i] <= 1'b1;
            if (!rd_v && idx >= count && !p1_v && !p2_v && !p3_v && !p4_v)
              state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_data.kept_x      <= best_box[14:0];
            out_data.kept_y      <= best_box[29:15];
            out_data.kept_width  <= best_box[44:30];
            out_data.kept_height <= best_box[59:45];
            out_data.kept_score  <= best_score;
            out_data.kept_class  <= best_class;
            out_data.last_kept   <= (removed == {MAX_BOXES{1'b1}}) ||
                                    ((removed | ~({MAX_BOXES{1'b1}} >> (MAX_BOXES - 32'(count))))
                                     == {MAX_BOXES{1'b1}});
            out_data.boxes_dropped <= overflow;
            state <= S_SCAN;
            idx <= '0;
            rd_v <= 1'b0;
            best_v <= 1'b0;
          end
        end
        S_DONE: begin
          count <= '0;
          overflow <= 1'b0;
          removed <= '0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

### tb/bnms_checker.sv
`timescale 1ns / 100ps
module bnms_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire bnms_pkg::box_in_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire bnms_pkg::box_out_t out_data,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [15:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);
  import bnms_pkg::*;

  localparam int CAPACITY = 64;

  box_in_t  frame_boxes[CAPACITY];
  int       frame_len;
  bit       frame_overflow;
  bit       gone[CAPACITY];
  logic [15:0] iou_thresh;
  box_out_t kept_queue[$];

  assign pending = kept_queue.size();

  // exact IoU test in doubled Q11.4 units
  function automatic bit too_close(box_in_t a, box_in_t b);
    longint al, ar, at, ab, bl, br, bt, bb, l, r, t, btm, inter, uni;
    al = 2 * longint'(a.center_x) - longint'(a.box_width);
    ar = 2 * longint'(a.center_x) + longint'(a.box_width);
    at = 2 * longint'(a.center_y) - longint'(a.box_height);
    ab = 2 * longint'(a.center_y) + longint'(a.box_height);
    bl = 2 * longint'(b.center_x) - longint'(b.box_width);
    br = 2 * longint'(b.center_x) + longint'(b.box_width);
    bt = 2 * longint'(b.center_y) - longint'(b.box_height);
    bb = 2 * longint'(b.center_y) + longint'(b.box_height);
    l   = (al > bl) ? al : bl;
    r   = (ar < br) ? ar : br;
    t   = (at > bt) ? at : bt;
    btm = (ab < bb) ? ab : bb;
    if (t > btm || l > r) return 0;
    inter = (r - l) * (btm - t);
    uni = 4 * longint'(a.box_width) * longint'(a.box_height)
        + 4 * longint'(b.box_width) * longint'(b.box_height) - inter;
    return inter * 65536 > longint'(iou_thresh) * uni;
  endfunction

  task automatic suppress_frame();
    int best;
    int n;
    box_out_t r;
    n = 0;
    forever begin
      best = -1;
      for (int i = 0; i < frame_len; i++)
        if (!gone[i] && (best < 0 ||
            frame_boxes[i].confidence > frame_boxes[best].confidence)) best = i;
      if (best < 0) break;
      gone[best] = 1;
      for (int i = 0; i < frame_len; i++)
        if (!gone[i] && too_close(frame_boxes[best], frame_boxes[i])) gone[i] = 1;
      r.kept_x        = frame_boxes[best].center_x;
      r.kept_y        = frame_boxes[best].center_y;
      r.kept_width    = frame_boxes[best].box_width;
      r.kept_height   = frame_boxes[best].box_height;
      r.kept_score    = frame_boxes[best].confidence;
      r.kept_class    = frame_boxes[best].class_index;
      r.last_kept     = 0;
      r.boxes_dropped = frame_overflow;
      kept_queue = {kept_queue, r};
      n++;
    end
    if (n > 0) kept_queue[kept_queue.size() - 1].last_kept = 1;
    frame_len = 0;
    frame_overflow = 0;
    for (int i = 0; i < CAPACITY; i++) gone[i] = 0;
  endtask

  always @(posedge clk) begin
    box_out_t want;
    if (rst) begin
      frame_len = 0;
      frame_overflow = 0;
      iou_thresh = THRESH_RESET;
      fail_count = 0;
      for (int i = 0; i < CAPACITY; i++) gone[i] = 0;
      kept_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) iou_thresh = cfg_data;
      if (out_valid && !out_stall) begin
        if (kept_queue.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected word %h", out_data);
        end else begin
          want = kept_queue.pop_front();
          if (want !== out_data) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) $display("mismatch: want %h got %h", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (frame_len < CAPACITY) begin
          frame_boxes[frame_len] = in_data;
          gone[frame_len] = 0;
          frame_len = frame_len + 1;
        end else frame_overflow = 1;
        if (in_data.frame_end) suppress_frame();
      end
    end
  end
endmodule

### tb/tb_box_non_max_suppression_top.sv
`timescale 1ns / 100ps
module tb_box_non_max_suppression_top;
  import bnms_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_stall = 0;
  logic cfg_valid = 0;
  logic [15:0] cfg_data = '0;
  box_in_t in_data = '0;
  logic in_stall, out_valid, cfg_ready;
  box_out_t out_data;
  int fail_count, pending;
  bit calm; // no idling while set

  always #10 clk = ~clk;

  box_non_max_suppression_top dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_data
  );

  bnms_checker chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
  );

  // receiver stalls at random, about 7 in 100 times, unless calm is set
  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 7);

  // send one word, honouring the stall handshake; valid is left high after
  // the word is taken and the next call or drain() drops or replaces it
  task automatic send_word(box_in_t w);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    // stall only moves at the rising edge, so it is stable here
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  // drain, then allow the pipeline to settle before touching the register
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_thresh(logic [15:0] t);
    drain();
    cfg_valid <= 1;
    cfg_data  <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic box_in_t rand_box(bit last, int span);
    box_in_t b;
    b.center_x    = 15'($urandom_range(span));
    b.center_y    = 15'($urandom_range(span));
    b.box_width   = 15'($urandom_range(span));
    b.box_height  = 15'($urandom_range(span));
    b.confidence  = 16'($urandom);
    b.class_index = 8'($urandom);
    b.frame_end   = last;
    return b;
  endfunction

  function automatic box_in_t mk(int x, int y, int w, int h, int c, bit last);
    box_in_t b;
    b = '{15'(x), 15'(y), 15'(w), 15'(h), 16'(c), 8'(c), last};
    return b;
  endfunction

  initial begin
    int sent, len, span;
    repeat (9) @(negedge clk);
    rst <= 0;
    calm = 0;
    // directed: extremes, equal scores, touching and zero-area boxes
    send_word(mk(32767, 32767, 32767, 32767, 65535, 0));
    send_word(mk(0, 0, 0, 0, 0, 0));
    send_word(mk(100, 100, 40, 40, 500, 0));
    send_word(mk(102, 100, 40, 40, 500, 0));   // equal score, overlaps
    send_word(mk(140, 100, 40, 40, 400, 0));   // edge touches the box at x=100
    send_word(mk(16383, 0, 0, 32767, 255, 1));
    send_word(mk(5, 5, 2, 2, 65535, 1));      // one-box frame
    set_thresh(16'd0);
    send_word(mk(100, 100, 40, 40, 1, 0));
    send_word(mk(110, 100, 40, 40, 2, 0));
    send_word(mk(0, 0, 0, 0, 3, 1));
    set_thresh(16'hFFFF);
    send_word(mk(100, 100, 40, 40, 9, 0));
    send_word(mk(100, 100, 40, 40, 9, 1));     // identical boxes
    // overflow: 66 boxes in one frame
    set_thresh(THRESH_RESET);
    for (int i = 0; i < 66; i++) send_word(rand_box(i == 65, 2000));
    sent = 0;
    while (sent < 390) begin
      if ($urandom_range(9) == 0) set_thresh(16'($urandom));
      calm = (sent > 200 && sent < 280);
      len = $urandom_range(1, 12);
      span = ($urandom_range(3) == 0) ? 32767 : 300;
      for (int i = 0; i < len; i++) begin
        box_in_t b;
        b = rand_box(i == len - 1, span);
        if (span != 32767) begin
          b.center_x = b.center_x + 15'd2000;
          b.center_y = b.center_y + 15'd2000;
        end
        send_word(b);
      end
      sent += len;
      if (sent > 100 && sent < 115) drain();
    end
    calm = 0;
    drain();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end
endmodule
